// ----- hw/rtl/dqmtf_pkg.sv -----
`timescale 1ns / 1ps

package dqmtf_pkg;

   localparam int VALUE_W  = 32;
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 2;

   // command codes carried on req_cmd
   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_DROP_FRONT = 3'd2,
      CMD_DROP_BACK  = 3'd3,
      CMD_MOVE_FRONT = 3'd4
   } cmd_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      RS_OK     = 2'd0,
      RS_EMPTY  = 2'd1,
      RS_BADPOS = 2'd2,
      RS_FULL   = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_PUSH,
      S_WALK,
      S_LOAD,
      S_MV_LINK,
      S_MV_FRONT,
      S_RESP
   } state_type;

   // write strobes toward the list store
   typedef struct packed {
      logic link_we;
      logic entry_we;
   } wr_type;

endpackage

// ----- hw/rtl/deque_with_move_to_front.sv -----
`timescale 1ns / 1ps

// Bounded deque of signed 32-bit values with move-to-front, kept as a linked
// chain of slots in a small store with one read and one write port for links
// and for values. A command is taken when start is high and busy is low;
// busy then stays high until the result beat, which shows on the rsp_ ports
// for exactly one cycle with rsp_strobe high and cannot be held off.
// A push goes through S_PUSH. Drop front with two or more entries and drop
// back with three or more walk links in S_WALK (count-2 from the front for
// drop back), then load the new end value in S_LOAD. Move of position n walks
// to it, then relinks in S_MV_LINK and S_MV_FRONT. Rejected and no-op commands,
// a drop that empties the list and a drop back from two entries go to S_RESP.
// The link walk advances one slot per cycle through the registered read port
// of the link store, and that walk sets the latency. A new command may be
// started in the cycle after the result beat. No clearing pass after reset.
module deque_with_move_to_front #(
   parameter int CAPACITY = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [dqmtf_pkg::CMD_W-1:0]           req_cmd,
   input  logic signed [dqmtf_pkg::VALUE_W-1:0]  req_value,
   input  logic [$clog2(CAPACITY+1)-1:0]         req_position,
   output logic                                  rsp_strobe,
   output logic [dqmtf_pkg::STATUS_W-1:0]        rsp_status,
   output logic [$clog2(CAPACITY+1)-1:0]         rsp_entry_count,
   output logic signed [dqmtf_pkg::VALUE_W-1:0]  rsp_front_value,
   output logic signed [dqmtf_pkg::VALUE_W-1:0]  rsp_back_value
);
   import dqmtf_pkg::*;

   localparam int SLOT_W  = $clog2(CAPACITY);
   localparam int COUNT_W = $clog2(CAPACITY+1);

   state_type                  state_ff, state_in;
   cmd_type                    cmd_ff, cmd_in;
   logic signed [VALUE_W-1:0]  value_ff, value_in;
   status_type                 status_ff, status_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic [COUNT_W-1:0]         hwm_ff, hwm_in;
   logic [SLOT_W-1:0]          front_ff, front_in;
   logic [SLOT_W-1:0]          back_ff, back_in;
   logic [SLOT_W-1:0]          free_head_ff, free_head_in;
   logic signed [VALUE_W-1:0]  fv_ff, fv_in;
   logic signed [VALUE_W-1:0]  bv_ff, bv_in;
   logic [SLOT_W-1:0]          prev_ff, prev_in;
   logic [SLOT_W-1:0]          tgt_ff, tgt_in;
   logic [SLOT_W-1:0]          dist_ff, dist_in;
   logic [SLOT_W-1:0]          steps_ff, steps_in;

   wr_type                     wr;
   logic [SLOT_W-1:0]          link_waddr, link_wdata, link_raddr, link_rdata;
   logic [SLOT_W-1:0]          entry_waddr, entry_raddr;
   logic [VALUE_W-1:0]         entry_rdata;
   logic [SLOT_W-1:0]          new_slot;
   logic                       take_free;
   logic                       accept;
   cmd_type                    req_code;
   logic                       walk_done;

   assign accept    = start && (state_ff == S_IDLE);
   assign req_code  = cmd_type'(req_cmd);
   assign walk_done = (dist_ff == steps_ff);
   // released slots wait on the free chain while the high-water mark exceeds the count
   assign take_free = (hwm_ff != count_ff);
   assign new_slot  = take_free ? free_head_ff : hwm_ff[SLOT_W-1:0];

   dqmtf_store #(
      .CAPACITY (CAPACITY)
   ) u_store (
      .clock       (clock),
      .wr          (wr),
      .link_waddr  (link_waddr),
      .link_wdata  (link_wdata),
      .link_raddr  (link_raddr),
      .link_rdata  (link_rdata),
      .entry_waddr (entry_waddr),
      .entry_wdata (value_ff),
      .entry_raddr (entry_raddr),
      .entry_rdata (entry_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_RESP;
               unique case (req_code) inside
                  CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                     if (count_ff != COUNT_W'(CAPACITY)) begin
                        state_in = S_PUSH;
                     end
                  end
                  CMD_DROP_FRONT: begin
                     if (count_ff > COUNT_W'(1)) begin
                        state_in = S_WALK;
                     end
                  end
                  CMD_DROP_BACK: begin
                     if (count_ff > COUNT_W'(2)) begin
                        state_in = S_WALK;
                     end
                  end
                  CMD_MOVE_FRONT: begin
                     if (count_ff != '0 && req_position > COUNT_W'(1) &&
                         req_position <= count_ff) begin
                        state_in = S_WALK;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_PUSH:     state_in = S_RESP;
         S_WALK: begin
            if (walk_done) begin
               state_in = (cmd_ff == CMD_MOVE_FRONT) ? S_MV_LINK : S_LOAD;
            end
         end
         S_LOAD:     state_in = S_RESP;
         S_MV_LINK:  state_in = S_MV_FRONT;
         S_MV_FRONT: state_in = S_RESP;
         S_RESP:     state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath and store control
   always_comb begin
      cmd_in       = cmd_ff;
      value_in     = value_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      hwm_in       = hwm_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      free_head_in = free_head_ff;
      fv_in        = fv_ff;
      bv_in        = bv_ff;
      prev_in      = prev_ff;
      tgt_in       = tgt_ff;
      dist_in      = dist_ff;
      steps_in     = steps_ff;
      wr           = '0;
      link_waddr   = front_ff;
      link_wdata   = free_head_ff;
      link_raddr   = link_rdata;
      entry_waddr  = new_slot;
      entry_raddr  = link_rdata;

      unique case (state_ff)
         S_IDLE: begin
            // fetch the free chain head for a push, else the front's successor
            link_raddr = (req_code == CMD_PUSH_FRONT || req_code == CMD_PUSH_BACK) ?
                         free_head_ff : front_ff;
            if (accept) begin
               cmd_in    = req_code;
               value_in  = req_value;
               status_in = RS_OK;
               dist_in   = SLOT_W'(1);
               prev_in   = front_ff;
               unique case (req_code) inside
                  CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                     if (count_ff == COUNT_W'(CAPACITY)) begin
                        status_in = RS_FULL;
                     end
                  end
                  CMD_DROP_FRONT, CMD_DROP_BACK: begin
                     if (count_ff == '0) begin
                        status_in = RS_EMPTY;
                     end else if (count_ff == COUNT_W'(1)) begin
                        // list empties: abandon the free chain
                        count_in = '0;
                        hwm_in   = '0;
                     end else if (req_code == CMD_DROP_BACK && count_ff == COUNT_W'(2)) begin
                        // front becomes the back; release the old back slot
                        back_in      = front_ff;
                        bv_in        = fv_ff;
                        wr.link_we   = 1'b1;
                        link_waddr   = back_ff;
                        free_head_in = back_ff;
                        count_in     = count_ff - COUNT_W'(1);
                     end else if (req_code == CMD_DROP_BACK) begin
                        steps_in = SLOT_W'(count_ff - COUNT_W'(2));
                     end else begin
                        steps_in = SLOT_W'(1);
                     end
                  end
                  CMD_MOVE_FRONT: begin
                     if (count_ff != '0 && req_position > COUNT_W'(1)) begin
                        if (req_position > count_ff) begin
                           status_in = RS_BADPOS;
                        end else begin
                           steps_in = SLOT_W'(req_position - COUNT_W'(1));
                        end
                     end
                  end
                  default: status_in = RS_OK;
               endcase
            end
         end

         S_PUSH: begin
            // take a slot from the free chain or above the high-water mark
            if (take_free) begin
               free_head_in = link_rdata;
            end else begin
               hwm_in = hwm_ff + COUNT_W'(1);
            end
            wr.entry_we = 1'b1;
            entry_waddr = new_slot;
            if (count_ff == '0) begin
               front_in = new_slot;
               back_in  = new_slot;
               fv_in    = value_ff;
               bv_in    = value_ff;
            end else if (cmd_ff == CMD_PUSH_FRONT) begin
               wr.link_we = 1'b1;
               link_waddr = new_slot;
               link_wdata = front_ff;
               front_in   = new_slot;
               fv_in      = value_ff;
            end else begin
               wr.link_we = 1'b1;
               link_waddr = back_ff;
               link_wdata = new_slot;
               back_in    = new_slot;
               bv_in      = value_ff;
            end
            count_in = count_ff + COUNT_W'(1);
         end

         S_WALK: begin
            // advance one link per cycle from the registered read data
            link_raddr  = link_rdata;
            entry_raddr = link_rdata;
            if (walk_done) begin
               case (cmd_ff)
                  CMD_DROP_FRONT: begin
                     wr.link_we   = 1'b1;
                     link_waddr   = front_ff;
                     free_head_in = front_ff;
                     front_in     = link_rdata;
                  end
                  CMD_DROP_BACK: begin
                     wr.link_we   = 1'b1;
                     link_waddr   = back_ff;
                     free_head_in = back_ff;
                     back_in      = link_rdata;
                  end
                  default: tgt_in = link_rdata;
               endcase
            end else begin
               prev_in = link_rdata;
               dist_in = dist_ff + SLOT_W'(1);
            end
         end

         S_LOAD: begin
            // pick up the new end value
            if (cmd_ff == CMD_DROP_FRONT) begin
               fv_in = $signed(entry_rdata);
            end else begin
               bv_in = $signed(entry_rdata);
            end
            count_in = count_ff - COUNT_W'(1);
         end

         S_MV_LINK: begin
            // unlink the target; its predecessor becomes the back if needed
            fv_in       = $signed(entry_rdata);
            entry_raddr = prev_ff;
            if (tgt_ff == back_ff) begin
               back_in = prev_ff;
            end else begin
               wr.link_we = 1'b1;
               link_waddr = prev_ff;
               link_wdata = link_rdata;
            end
         end

         S_MV_FRONT: begin
            // splice the target in ahead of the old front
            wr.link_we = 1'b1;
            link_waddr = tgt_ff;
            link_wdata = front_ff;
            front_in   = tgt_ff;
            if (back_ff == prev_ff) begin
               bv_in = $signed(entry_rdata);
            end
         end

         S_RESP:  status_in = status_ff;
         default: status_in = status_ff;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= RS_OK;
         count_ff  <= '0;
         hwm_ff    <= '0;
         front_ff  <= '0;
         back_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
         count_ff  <= count_in;
         hwm_ff    <= hwm_in;
         front_ff  <= front_in;
         back_ff   <= back_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      value_ff     <= value_in;
      free_head_ff <= free_head_in;
      fv_ff        <= fv_in;
      bv_ff        <= bv_in;
      prev_ff      <= prev_in;
      tgt_ff       <= tgt_in;
      dist_ff      <= dist_in;
      steps_ff     <= steps_in;
   end

   // result beat
   assign busy            = (state_ff != S_IDLE);
   assign rsp_strobe      = (state_ff == S_RESP);
   assign rsp_status      = status_ff;
   assign rsp_entry_count = count_ff;
   assign rsp_front_value = (count_ff == '0) ? '0 : fv_ff;
   assign rsp_back_value  = (count_ff == '0) ? '0 : bv_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_hwm_cover: assert property (@(posedge clock) disable iff (reset)
      hwm_ff >= count_ff)
      else $error("high-water mark below entry count");

   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result beat longer than one cycle");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == RS_FULL) |-> (count_ff == COUNT_W'(CAPACITY)))
      else $error("full status with room left");

   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (dist_ff <= steps_ff))
      else $error("link walk overran its target");
`endif

endmodule

// ----- hw/rtl/dqmtf_store.sv -----
`timescale 1ns / 1ps

module dqmtf_store #(
   parameter int CAPACITY = 16
) (
   input  logic                                  clock,
   input  dqmtf_pkg::wr_type                     wr,
   input  logic [$clog2(CAPACITY)-1:0]           link_waddr,
   input  logic [$clog2(CAPACITY)-1:0]           link_wdata,
   input  logic [$clog2(CAPACITY)-1:0]           link_raddr,
   output logic [$clog2(CAPACITY)-1:0]           link_rdata,
   input  logic [$clog2(CAPACITY)-1:0]           entry_waddr,
   input  logic [dqmtf_pkg::VALUE_W-1:0]         entry_wdata,
   input  logic [$clog2(CAPACITY)-1:0]           entry_raddr,
   output logic [dqmtf_pkg::VALUE_W-1:0]         entry_rdata
);
   import dqmtf_pkg::*;

   localparam int SLOT_W = $clog2(CAPACITY);

   logic [SLOT_W-1:0]  link_mem  [CAPACITY];
   logic [VALUE_W-1:0] entry_mem [CAPACITY];

   // successor links: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr.link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rdata <= link_mem[link_raddr];
   end

   // entry values: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr.entry_we) begin
         entry_mem[entry_waddr] <= entry_wdata;
      end
      entry_rdata <= entry_mem[entry_raddr];
   end

endmodule

// ----- dv/deque_with_move_to_front_tb.sv -----
`timescale 1ns / 1ps

module deque_with_move_to_front_tb;
   import dqmtf_pkg::*;

   localparam int CAPACITY     = 16;
   localparam int CNT_W        = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] POS_MAX = '1;
   localparam int CLK_HALF     = 4;
   localparam int RESET_CYCLES = 8;
   localparam int RANDOM_ITEMS = 800;
   localparam int CYCLE_LIMIT  = 300000;
   // longest command is a move from the back
   localparam int TAIL_CYCLES  = 2 * CAPACITY + 8;
   localparam int GAP_PCT      = 35;

   // command codes the block does not define
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   localparam logic signed [VALUE_W-1:0] VAL_MIN  = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX  = 32'sh7fff_ffff;
   localparam logic signed [VALUE_W-1:0] VAL_ZERO = 32'sh0000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_ONES = 32'shffff_ffff;

   typedef struct {
      status_type                 status;
      logic [CNT_W-1:0]           count;
      logic signed [VALUE_W-1:0]  front;
      logic signed [VALUE_W-1:0]  back;
   } list_beat_type;

   typedef enum { MODE_FILL, MODE_CHURN, MODE_DRAIN } traffic_mode_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [CMD_W-1:0]            req_cmd = '0;
   logic signed [VALUE_W-1:0]   req_value = '0;
   logic [CNT_W-1:0]            req_position = '0;
   logic                        rsp_strobe;
   logic [STATUS_W-1:0]         rsp_status;
   logic [CNT_W-1:0]            rsp_entry_count;
   logic signed [VALUE_W-1:0]   rsp_front_value;
   logic signed [VALUE_W-1:0]   rsp_back_value;

   logic signed [VALUE_W-1:0]   list_model[$];
   list_beat_type               expected_beats[$];
   int                          error_count = 0;
   int                          cycle_count = 0;
   bit                          gaps_on = 1'b1;

   deque_with_move_to_front #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_value(req_value),
      .req_position(req_position),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_entry_count(rsp_entry_count),
      .rsp_front_value(rsp_front_value),
      .rsp_back_value(rsp_back_value)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // end the run if the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // apply one command to the list and return the beat it should produce
   function automatic list_beat_type apply_list_cmd(input logic [CMD_W-1:0] cmd,
                                                    input logic signed [VALUE_W-1:0] value,
                                                    input logic [CNT_W-1:0] pos);
      list_beat_type              beat;
      logic signed [VALUE_W-1:0]  moved;
      beat.status = RS_OK;
      case (cmd)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (list_model.size() >= CAPACITY)
               beat.status = RS_FULL;
            else if (cmd == CMD_PUSH_FRONT)
               list_model.push_front(value);
            else
               list_model.push_back(value);
         end
         CMD_DROP_FRONT, CMD_DROP_BACK: begin
            if (list_model.size() == 0)
               beat.status = RS_EMPTY;
            else if (cmd == CMD_DROP_FRONT)
               void'(list_model.pop_front());
            else
               void'(list_model.pop_back());
         end
         CMD_MOVE_FRONT: begin
            // position 0 or 1, or an empty list, leaves everything alone
            if (list_model.size() != 0 && pos > 1) begin
               if (pos > list_model.size()) begin
                  beat.status = RS_BADPOS;
               end else begin
                  moved = list_model[pos - 1];
                  list_model.delete(pos - 1);
                  list_model.push_front(moved);
               end
            end
         end
         default: ;
      endcase
      beat.count = CNT_W'(list_model.size());
      beat.front = (list_model.size() != 0) ? list_model[0] : VAL_ZERO;
      beat.back  = (list_model.size() != 0) ? list_model[list_model.size() - 1] : VAL_ZERO;
      return beat;
   endfunction

   function automatic logic signed [VALUE_W-1:0] rand_value();
      case ($urandom_range(0, 9))
         0: return VAL_MIN;
         1: return VAL_MAX;
         2: return VAL_ZERO;
         3: return VAL_ONES;
         default: return $urandom();
      endcase
   endfunction

   // mostly legal move targets, some no-op and out-of-range positions
   function automatic logic [CNT_W-1:0] pick_position(input int cnt);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10)
         return CNT_W'($urandom_range(0, 1));
      if (roll < 22)
         return CNT_W'($urandom_range(cnt + 1, POS_MAX));
      if (cnt >= 2)
         return CNT_W'($urandom_range(2, cnt));
      return CNT_W'($urandom_range(0, POS_MAX));
   endfunction

   task automatic check_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   // drive one command beat, with a random hold-off first, and wait for accept
   task automatic send_cmd(input logic [CMD_W-1:0] cmd,
                           input logic signed [VALUE_W-1:0] value,
                           input logic [CNT_W-1:0] pos);
      int gap;
      gap = 0;
      if (gaps_on && $urandom_range(0, 99) < GAP_PCT)
         gap = $urandom_range(1, 6);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_cmd      <= cmd;
      req_value    <= value;
      req_position <= pos;
      do @(posedge clock); while (busy);
      expected_beats.push_back(apply_list_cmd(cmd, value, pos));
   endtask

   // hold off new commands until every result beat is back
   task automatic wait_for_results();
      start <= 1'b0;
      do @(posedge clock); while (expected_beats.size() != 0);
   endtask

   // compare each result beat against the oldest expectation
   always @(posedge clock) begin
      list_beat_type want;
      if (!reset && rsp_strobe) begin
         if (expected_beats.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result beat, status %0d count %0d", $time,
                     rsp_status, rsp_entry_count);
         end else begin
            want = expected_beats.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("entry_count", want.count, rsp_entry_count);
            check_field("front_value", want.front, rsp_front_value);
            check_field("back_value", want.back, rsp_back_value);
         end
      end
   end

   task automatic test_empty_list();
      send_cmd(CMD_DROP_FRONT, rand_value(), pick_position(0));
      send_cmd(CMD_DROP_BACK, rand_value(), pick_position(0));
      send_cmd(CMD_MOVE_FRONT, rand_value(), 5'd3);
      send_cmd(CMD_MOVE_FRONT, rand_value(), 5'd0);
   endtask

   task automatic test_push_extremes();
      send_cmd(CMD_PUSH_FRONT, VAL_MIN, 5'd0);
      send_cmd(CMD_PUSH_BACK, VAL_MAX, POS_MAX);
      send_cmd(CMD_PUSH_FRONT, VAL_ONES, 5'd1);
      send_cmd(CMD_PUSH_BACK, VAL_ZERO, 5'd16);
   endtask

   // list holds four entries here
   task automatic test_move_cases();
      send_cmd(CMD_MOVE_FRONT, rand_value(), 5'd1);
      send_cmd(CMD_MOVE_FRONT, rand_value(), 5'd0);
      send_cmd(CMD_MOVE_FRONT, rand_value(), 5'd5);
      send_cmd(CMD_MOVE_FRONT, rand_value(), POS_MAX);
      send_cmd(CMD_MOVE_FRONT, rand_value(), 5'd4);
      send_cmd(CMD_MOVE_FRONT, rand_value(), 5'd2);
      send_cmd(CMD_MOVE_FRONT, rand_value(), 5'd3);
   endtask

   task automatic test_spare_codes();
      for (int code = CMD_SPARE_LO; code <= CMD_SPARE_HI; code++)
         send_cmd(CMD_W'(code), rand_value(), pick_position(list_model.size()));
   endtask

   task automatic test_drop_to_empty();
      send_cmd(CMD_DROP_BACK, rand_value(), 5'd0);
      send_cmd(CMD_DROP_FRONT, rand_value(), 5'd0);
      send_cmd(CMD_DROP_BACK, rand_value(), 5'd0);
      send_cmd(CMD_DROP_FRONT, rand_value(), 5'd0);
   endtask

   // cycle through fill, churn and drain so the list hits full and empty often
   task automatic test_random_traffic(input int n_items);
      traffic_mode_type  mode;
      int                bound_hits;
      int                churn_left;
      int                cnt;
      int                roll;
      int                push_pct;
      int                drop_pct;
      int                move_pct;
      logic [CMD_W-1:0]  cmd;
      mode       = MODE_FILL;
      bound_hits = 0;
      churn_left = 0;
      for (int i = 0; i < n_items; i++) begin
         // keep one long stretch free of hold-offs
         gaps_on = (i < 300 || i >= 450);
         if (i == 500)
            wait_for_results();
         cnt = list_model.size();
         case (mode)
            MODE_FILL: begin
               if (cnt == CAPACITY)
                  bound_hits++;
               if (bound_hits >= 3) begin
                  mode       = MODE_CHURN;
                  churn_left = $urandom_range(40, 80);
                  bound_hits = 0;
               end
            end
            MODE_CHURN: begin
               churn_left--;
               if (churn_left <= 0)
                  mode = MODE_DRAIN;
            end
            default: begin
               if (cnt == 0)
                  bound_hits++;
               if (bound_hits >= 3) begin
                  mode       = MODE_FILL;
                  bound_hits = 0;
               end
            end
         endcase
         case (mode)
            MODE_FILL:  begin push_pct = 70; drop_pct = 10; move_pct = 15; end
            MODE_CHURN: begin push_pct = 25; drop_pct = 25; move_pct = 45; end
            default:    begin push_pct = 10; drop_pct = 70; move_pct = 15; end
         endcase
         roll = $urandom_range(0, 99);
         if (roll < push_pct)
            cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
         else if (roll < push_pct + drop_pct)
            cmd = $urandom_range(0, 1) ? CMD_DROP_FRONT : CMD_DROP_BACK;
         else if (roll < push_pct + drop_pct + move_pct)
            cmd = CMD_MOVE_FRONT;
         else
            cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
         send_cmd(cmd, rand_value(), pick_position(cnt));
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_empty_list();
      test_push_extremes();
      test_move_cases();
      test_spare_codes();
      test_drop_to_empty();
      test_random_traffic(RANDOM_ITEMS);
      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
